/* rtl/fbcm_pkg.sv */
// Shared types, codes and mask helpers for the block chain manager.
package fbcm_pkg;

  localparam int BLOCK_COUNT_DEF = 4096;
  localparam int FIRST_DATA_BLOCK_DEF = 130;

  localparam int MAP_W = 64;
  localparam int MAP_BIT_W = 6;

  typedef enum logic [2:0] {
    OP_ALLOC      = 3'd0,
    OP_APPEND     = 3'd1,
    OP_FREE_CHAIN = 3'd2,
    OP_FREE_ONE   = 3'd3,
    OP_WALK       = 3'd4
  } fbcm_op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_ENDED   = 2'd2
  } fbcm_status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_TAIL_RD,
    S_TAIL_EV,
    S_SRCH_RD,
    S_SRCH_EV,
    S_APP_LINK,
    S_FREE_RD,
    S_FREE_EV,
    S_ONE_RD,
    S_ONE_EV,
    S_WALK_RD,
    S_WALK_EV,
    S_DONE
  } fbcm_state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [11:0] head_block;
    logic [11:0] link_steps;
  } fbcm_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] result_block;
    logic [12:0] freed_count;
  } fbcm_out_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } fbcm_mem_ctl_t;

  // Bits of one bitmap word that belong to reserved blocks.
  function automatic logic [MAP_W-1:0] reserved_mask(input logic [16:0] word, input int first);
    logic [MAP_W-1:0] m;
    logic [22:0]      b;
    m = '0;
    for (int j = 0; j < MAP_W; j++) begin
      b = {word, MAP_BIT_W'(j)};
      m[j] = (int'(b) < first);
    end
    return m;
  endfunction

  // Bits of one bitmap word that the free search may pick.
  function automatic logic [MAP_W-1:0] usable_mask(input logic [16:0] word, input int first,
                                                   input int count);
    logic [MAP_W-1:0] m;
    logic [22:0]      b;
    m = '0;
    for (int j = 0; j < MAP_W; j++) begin
      b = {word, MAP_BIT_W'(j)};
      m[j] = (int'(b) >= first) && (int'(b) < count);
    end
    return m;
  endfunction

  function automatic logic [MAP_BIT_W-1:0] lowest_set(input logic [MAP_W-1:0] v);
    logic [MAP_BIT_W-1:0] idx;
    idx = '0;
    for (int j = MAP_W - 1; j >= 0; j--) begin
      if (v[j]) begin
        idx = MAP_BIT_W'(j);
      end
    end
    return idx;
  endfunction

endpackage

/* rtl/fbcm_map.sv */
// Used-block bitmap memory with the lowest-free-bit search on its read word.
module fbcm_map
  import fbcm_pkg::*;
#(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
  parameter int FIRST_DATA_BLOCK = FIRST_DATA_BLOCK_DEF,
  localparam int WORDS = (BLOCK_COUNT + MAP_W - 1) / MAP_W,
  localparam int WAW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                 clk,
  input  fbcm_mem_ctl_t        ctl,
  input  logic [WAW-1:0]       waddr,
  input  logic [MAP_W-1:0]     wdata,
  input  logic [WAW-1:0]       raddr,
  output logic [MAP_W-1:0]     rdata,
  output logic                 found,
  output logic [MAP_BIT_W-1:0] free_bit
);

  logic [MAP_W-1:0] mem [WORDS];
  logic [MAP_W-1:0] rdata_r;
  logic [WAW-1:0]   raddr_r;
  logic [MAP_W-1:0] cand;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd) begin
      rdata_r <= mem[raddr];
      raddr_r <= raddr;
    end
  end

  assign cand     = ~rdata_r & usable_mask(17'(raddr_r), FIRST_DATA_BLOCK, BLOCK_COUNT);
  assign found    = |cand;
  assign free_bit = lowest_set(cand);
  assign rdata    = rdata_r;

endmodule

/* rtl/fbcm_engine.sv */
// Operation sequencer with the link memory and the bitmap store.
module fbcm_engine
  import fbcm_pkg::*;
#(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
  parameter int FIRST_DATA_BLOCK = FIRST_DATA_BLOCK_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  fbcm_in_t  in_item,
  input  logic      res_ready,
  output logic      idle,
  output logic      done,
  output fbcm_out_t res
);

  localparam int BW = $clog2(BLOCK_COUNT);
  localparam int LW = BW + 1;
  localparam int WORDS = (BLOCK_COUNT + MAP_W - 1) / MAP_W;
  localparam int WAW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [LW-1:0] END_MARK = LW'(BLOCK_COUNT);
  localparam logic [16:0] BLOCK_LIMIT = 17'(BLOCK_COUNT);
  localparam logic [WAW-1:0] START_WORD = WAW'(FIRST_DATA_BLOCK / MAP_W);
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

  fbcm_state_t state_r, state_nxt;

  logic [BW-1:0]    init_cnt_r;
  logic [2:0]       op_r;
  logic [BW-1:0]    cur_r;
  logic [BW-1:0]    tail_r;
  logic [11:0]      steps_r;
  logic [LW-1:0]    hops_r;
  logic [LW-1:0]    freed_r;
  logic [WAW-1:0]   word_r;
  logic [BW-1:0]    result_r;
  fbcm_status_t     status_r;

  logic [LW-1:0]    link_mem [BLOCK_COUNT];
  logic [LW-1:0]    link_rdata_r;
  fbcm_mem_ctl_t    link_ctl;
  logic [BW-1:0]    link_waddr;
  logic [LW-1:0]    link_wdata;
  logic [BW-1:0]    link_raddr;

  fbcm_mem_ctl_t        map_ctl;
  logic [WAW-1:0]       map_waddr;
  logic [MAP_W-1:0]     map_wdata;
  logic [WAW-1:0]       map_raddr;
  logic [MAP_W-1:0]     map_rdata;
  logic                 map_found;
  logic [MAP_BIT_W-1:0] map_free_bit;

  logic                 nx_end;
  logic [BW-1:0]        nx_blk;
  logic [WAW-1:0]       cur_word;
  logic [MAP_BIT_W-1:0] cur_bit;
  logic [WAW-1:0]       init_word;
  logic [BW-1:0]        found_blk;
  logic                 head_oob;
  logic                 hop_last;

  fbcm_map #(
    .BLOCK_COUNT      (BLOCK_COUNT),
    .FIRST_DATA_BLOCK (FIRST_DATA_BLOCK)
  ) u_map (
    .clk      (clk),
    .ctl      (map_ctl),
    .waddr    (map_waddr),
    .wdata    (map_wdata),
    .raddr    (map_raddr),
    .rdata    (map_rdata),
    .found    (map_found),
    .free_bit (map_free_bit)
  );

  always_ff @(posedge clk) begin
    if (link_ctl.wr) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_ctl.rd) begin
      link_rdata_r <= link_mem[link_raddr];
    end
  end

  assign nx_end    = (link_rdata_r >= END_MARK);
  assign nx_blk    = BW'(link_rdata_r);
  assign cur_word  = WAW'(cur_r >> MAP_BIT_W);
  assign cur_bit   = MAP_BIT_W'(cur_r);
  assign init_word = WAW'(init_cnt_r >> MAP_BIT_W);
  assign found_blk = BW'({word_r, map_free_bit});
  assign head_oob  = ({5'd0, in_item.head_block} >= BLOCK_LIMIT) &&
                     (in_item.opcode == OP_APPEND || in_item.opcode == OP_FREE_CHAIN ||
                      in_item.opcode == OP_FREE_ONE || in_item.opcode == OP_WALK);
  assign hop_last  = (hops_r == LW'(BLOCK_COUNT - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (init_cnt_r == BW'(BLOCK_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (head_oob) begin
            state_nxt = S_DONE;
          end else begin
            unique case (in_item.opcode)
              OP_ALLOC:      state_nxt = S_SRCH_RD;
              OP_APPEND:     state_nxt = S_TAIL_RD;
              OP_FREE_CHAIN: state_nxt = S_FREE_RD;
              OP_FREE_ONE:   state_nxt = S_ONE_RD;
              OP_WALK:       state_nxt = S_WALK_RD;
              default:       state_nxt = S_DONE;
            endcase
          end
        end
      end
      S_TAIL_RD: state_nxt = S_TAIL_EV;
      S_TAIL_EV: begin
        if (nx_end) begin
          state_nxt = S_SRCH_RD;
        end else if (hop_last) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_TAIL_RD;
        end
      end
      S_SRCH_RD: state_nxt = S_SRCH_EV;
      S_SRCH_EV: begin
        if (map_found) begin
          state_nxt = (op_r == OP_APPEND) ? S_APP_LINK : S_DONE;
        end else if (word_r == LAST_WORD) begin
          state_nxt = S_DONE;
        end
      end
      S_APP_LINK: state_nxt = S_DONE;
      S_FREE_RD: begin
        state_nxt = (freed_r == END_MARK) ? S_DONE : S_FREE_EV;
      end
      S_FREE_EV: state_nxt = nx_end ? S_DONE : S_FREE_RD;
      S_ONE_RD:  state_nxt = S_ONE_EV;
      S_ONE_EV:  state_nxt = S_DONE;
      S_WALK_RD: state_nxt = (steps_r == '0) ? S_DONE : S_WALK_EV;
      S_WALK_EV: state_nxt = nx_end ? S_DONE : S_WALK_RD;
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_comb begin
    link_ctl   = '0;
    link_waddr = cur_r;
    link_wdata = END_MARK;
    link_raddr = cur_r;
    map_ctl    = '0;
    map_waddr  = cur_word;
    map_wdata  = map_rdata & ~(MAP_W'(1) << cur_bit);
    map_raddr  = cur_word;
    idle       = 1'b0;
    done       = 1'b0;
    unique case (state_r)
      S_INIT: begin
        link_ctl.wr = 1'b1;
        link_waddr  = init_cnt_r;
        map_ctl.wr  = 1'b1;
        map_waddr   = init_word;
        map_wdata   = reserved_mask(17'(init_word), FIRST_DATA_BLOCK);
      end
      S_IDLE: idle = 1'b1;
      S_TAIL_RD, S_WALK_RD: link_ctl.rd = 1'b1;
      S_SRCH_RD: begin
        map_ctl.rd = 1'b1;
        map_raddr  = word_r;
      end
      S_SRCH_EV: begin
        map_raddr  = word_r + 1'b1;
        map_ctl.rd = !map_found && (word_r != LAST_WORD);
        if (map_found) begin
          map_ctl.wr  = 1'b1;
          map_waddr   = word_r;
          map_wdata   = map_rdata | (MAP_W'(1) << map_free_bit);
          link_ctl.wr = 1'b1;
          if (op_r == OP_APPEND) begin
            link_waddr = tail_r;
            link_wdata = LW'(found_blk);
          end else begin
            link_waddr = found_blk;
          end
        end
      end
      S_APP_LINK: begin
        link_ctl.wr = 1'b1;
        link_waddr  = result_r;
      end
      S_FREE_RD: begin
        link_ctl.rd = 1'b1;
        map_ctl.rd  = 1'b1;
      end
      S_FREE_EV: begin
        link_ctl.wr = 1'b1;
        map_ctl.wr  = 1'b1;
      end
      S_ONE_RD: map_ctl.rd = 1'b1;
      S_ONE_EV: map_ctl.wr = 1'b1;
      S_WALK_EV: ;
      S_DONE: done = res_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      init_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INIT) begin
        init_cnt_r <= init_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_r     <= in_item.opcode;
          cur_r    <= BW'(in_item.head_block);
          steps_r  <= in_item.link_steps;
          hops_r   <= '0;
          freed_r  <= '0;
          word_r   <= START_WORD;
          result_r <= '0;
          status_r <= head_oob ? ST_ENDED : ST_OK;
        end
      end
      S_TAIL_EV: begin
        if (nx_end) begin
          tail_r <= cur_r;
        end else if (hop_last) begin
          status_r <= ST_ENDED;
        end else begin
          cur_r  <= nx_blk;
          hops_r <= hops_r + 1'b1;
        end
      end
      S_SRCH_EV: begin
        if (map_found) begin
          result_r <= found_blk;
        end else if (word_r == LAST_WORD) begin
          status_r <= ST_NO_FREE;
        end else begin
          word_r <= word_r + 1'b1;
        end
      end
      S_FREE_RD: begin
        if (freed_r == END_MARK) begin
          status_r <= ST_ENDED;
        end
      end
      S_FREE_EV: begin
        freed_r <= freed_r + 1'b1;
        cur_r   <= nx_blk;
      end
      S_WALK_RD: begin
        if (steps_r == '0) begin
          result_r <= cur_r;
        end
      end
      S_WALK_EV: begin
        if (nx_end) begin
          status_r <= ST_ENDED;
          result_r <= cur_r;
        end else begin
          cur_r   <= nx_blk;
          steps_r <= steps_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res.status       = status_r;
  assign res.result_block = 12'(result_r);
  assign res.freed_count  = 13'(freed_r);

`ifndef SYNTHESIS
  ap_link_wdata: assert property (@(posedge clk) disable iff (!rst_n)
    link_ctl.wr |-> (link_wdata <= END_MARK))
    else $error("link write carries a block number beyond the end marker");

  ap_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> res_ready)
    else $error("item finished while the output register was full");

  ap_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == S_IDLE))
    else $error("item accepted while an operation was in progress");

  ap_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after finishing an item");

  ap_found_usable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH_EV && map_found) |->
      (int'(found_blk) >= FIRST_DATA_BLOCK && int'(found_blk) < BLOCK_COUNT))
    else $error("free search picked a reserved or nonexistent block");
`endif

endmodule

/* rtl/fat_block_chain_manager_top.sv */
// Top level: handshake, operation engine and output register; one item in flight at a time.
// Alloc scans the bitmap one 64-block word at a time for the lowest free data block; append
// first follows the links to the tail, then does the same scan and links the new block; free
// chain frees each block in turn; walk follows up to link_steps links; free one clears one bit.
// in_stall drops when out_valid rises, so the next item can then be taken; a stalled output holds the engine.
// After reset the tables are cleared block by block while in_stall stays high.
module fat_block_chain_manager_top
  import fbcm_pkg::*;
#(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
  parameter int FIRST_DATA_BLOCK = FIRST_DATA_BLOCK_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  fbcm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output fbcm_out_t out_data
);

  logic      eng_idle;
  logic      eng_done;
  logic      res_ready;
  logic      start;
  fbcm_out_t eng_res;
  logic      out_valid_r;
  fbcm_out_t out_data_r;

  assign in_stall  = !eng_idle;
  assign start     = in_valid && !in_stall;
  assign res_ready = !out_valid_r || !out_stall;

  fbcm_engine #(
    .BLOCK_COUNT      (BLOCK_COUNT),
    .FIRST_DATA_BLOCK (FIRST_DATA_BLOCK)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_data),
    .res_ready (res_ready),
    .idle      (eng_idle),
    .done      (eng_done),
    .res       (eng_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done) begin
      out_data_r <= eng_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the block chain manager: directed, random and allocation bursts.
module testbench;
  import fbcm_pkg::*;

  localparam int BLOCKS = BLOCK_COUNT_DEF;
  localparam int FIRST = FIRST_DATA_BLOCK_DEF;
  localparam int END_LINK = BLOCKS;
  localparam int RANDOM_ITEMS = 1450;
  localparam int BURST_ITEMS = 100;
  localparam int MAX_HEADS = 48;
  localparam int MAX_CHAIN = 40;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int MAX_REPORTS = 40;
  localparam logic [2:0] OP_UNUSED_FIRST = 3'(OP_WALK) + 3'd1;
  localparam logic [2:0] OP_UNUSED_LAST = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  fbcm_in_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  fbcm_out_t out_data;

  bit          blk_used [BLOCKS];
  logic [12:0] blk_next [BLOCKS];

  fbcm_out_t expected_results[$];
  fbcm_out_t last_outcome;
  int        chain_heads[$];
  int        op_count[8];
  int        status_count[4];
  int        real_items = 0;
  int        checked_count = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  int        burst_left = 0;
  int        stall_run = 0;
  bit        steady_flow = 1'b0;

  fat_block_chain_manager_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int lowest_free_block();
    for (int b = FIRST; b < BLOCKS; b++) begin
      if (!blk_used[b]) begin
        return b;
      end
    end
    return END_LINK;
  endfunction

  function automatic int chain_length(input int blk);
    int n;
    n = 0;
    while (blk_next[blk] < END_LINK && n < BLOCKS) begin
      blk = blk_next[blk];
      n++;
    end
    return n;
  endfunction

  function automatic fbcm_out_t apply_op(input fbcm_in_t item);
    fbcm_out_t   res;
    int          cur;
    int          nxt;
    int          tail;
    int          pick;
    int unsigned freed;
    res = '0;
    cur = item.head_block;
    freed = 0;
    case (item.opcode)
      OP_ALLOC: begin
        pick = lowest_free_block();
        if (pick == END_LINK) begin
          res.status = ST_NO_FREE;
        end else begin
          blk_used[pick] = 1'b1;
          blk_next[pick] = 13'(END_LINK);
          res.result_block = 12'(pick);
        end
      end
      OP_APPEND: begin
        tail = END_LINK;
        for (int n = 0; n < BLOCKS; n++) begin
          if (blk_next[cur] >= END_LINK) begin
            tail = cur;
            break;
          end
          cur = blk_next[cur];
        end
        pick = lowest_free_block();
        if (tail == END_LINK) begin
          res.status = ST_ENDED;
        end else if (pick == END_LINK) begin
          res.status = ST_NO_FREE;
        end else begin
          blk_next[tail] = 13'(pick);
          blk_used[pick] = 1'b1;
          blk_next[pick] = 13'(END_LINK);
          res.result_block = 12'(pick);
        end
      end
      OP_FREE_CHAIN: begin
        while (cur < END_LINK) begin
          if (freed >= BLOCKS) begin
            res.status = ST_ENDED;
            break;
          end
          nxt = blk_next[cur];
          blk_next[cur] = 13'(END_LINK);
          blk_used[cur] = 1'b0;
          freed++;
          cur = nxt;
        end
        res.freed_count = 13'(freed);
      end
      OP_FREE_ONE: begin
        blk_used[cur] = 1'b0;
      end
      OP_WALK: begin
        for (int n = 0; n < item.link_steps; n++) begin
          if (blk_next[cur] >= END_LINK) begin
            res.status = ST_ENDED;
            break;
          end
          cur = blk_next[cur];
        end
        res.result_block = 12'(cur);
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int wanted);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("ERROR cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, wanted);
    end
  endtask

  task automatic send_op(input logic [2:0] op, input int head, input int steps);
    fbcm_in_t item;
    int       idle;
    item.opcode = op;
    item.head_block = 12'(head);
    item.link_steps = 12'(steps);
    idle = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady_flow) begin
        idle = $urandom_range(0, 7);
      end
    end
    burst_left--;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    last_outcome = apply_op(item);
    expected_results.push_back(last_outcome);
    op_count[op]++;
    status_count[last_outcome.status]++;
    if (op <= OP_WALK) begin
      real_items++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (steady_flow || out_stall) begin
      out_stall <= 1'b0;
      stall_run <= $urandom_range(1, 15);
    end else begin
      out_stall <= 1'b1;
      stall_run <= $urandom_range(0, 5);
    end
  end

  always @(posedge clk) begin : result_check
    fbcm_out_t wanted;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item pending", int'(out_data.result_block), 0);
      end else begin
        wanted = expected_results.pop_front();
        checked_count++;
        if (out_data.status !== wanted.status) begin
          report_mismatch("status", int'(out_data.status), int'(wanted.status));
        end
        if (out_data.result_block !== wanted.result_block) begin
          report_mismatch("result_block", int'(out_data.result_block),
                          int'(wanted.result_block));
        end
        if (out_data.freed_count !== wanted.freed_count) begin
          report_mismatch("freed_count", int'(out_data.freed_count),
                          int'(wanted.freed_count));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending.", cycle_count,
               expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_corner_cases();
    steady_flow = 1'b1;
    send_op(OP_WALK, 0, 0);
    send_op(OP_WALK, BLOCKS - 1, 'hFFF);
    send_op(OP_ALLOC, 0, 0);
    send_op(OP_APPEND, FIRST, 0);
    send_op(OP_APPEND, FIRST, 'hFFF);
    send_op(OP_WALK, FIRST, 2);
    send_op(OP_WALK, FIRST, 3);
    send_op(OP_FREE_ONE, FIRST + 1, 0);
    send_op(OP_ALLOC, 'hFFF, 'hFFF);
    send_op(OP_WALK, FIRST, 'hFFF);
    send_op(OP_ALLOC, 'hAAA, 'h555);
    send_op(OP_FREE_ONE, FIRST + 3, 0);
    send_op(OP_APPEND, FIRST + 3, 0);
    send_op(OP_FREE_ONE, BLOCKS - 1, 0);
    send_op(OP_FREE_CHAIN, BLOCKS - 1, 0);
    send_op(OP_FREE_CHAIN, FIRST, 0);
    send_op(OP_FREE_CHAIN, 5, 0);
    send_op(OP_FREE_ONE, 0, 'hFFF);
    send_op(OP_WALK, 'hAAA, 'h555);
    send_op(OP_WALK, 'h555, 'hAAA);
    for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++) begin
      send_op(3'(op), 'hFFF, 'hFFF);
    end
    send_op(OP_FREE_CHAIN, FIRST + 3, 0);
  endtask

  task automatic test_random_mix();
    int start;
    int pick;
    int idx;
    int blk;
    int len;
    int steps;
    start = real_items;
    while (real_items - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 199) == 0) begin
        steady_flow = ($urandom_range(0, 2) == 0);
      end
      pick = $urandom_range(0, 99);
      if (chain_heads.size() == 0 || pick < 20) begin
        if (chain_heads.size() >= MAX_HEADS) begin
          send_op(OP_FREE_CHAIN, chain_heads[0], $urandom);
          chain_heads.delete(0);
        end else begin
          send_op(OP_ALLOC, $urandom, $urandom);
          if (last_outcome.status == ST_OK) begin
            chain_heads.push_back(int'(last_outcome.result_block));
          end
        end
      end else if (pick < 93) begin
        idx = $urandom_range(0, chain_heads.size() - 1);
        blk = chain_heads[idx];
        len = chain_length(blk);
        if (pick < 45 && len < MAX_CHAIN) begin
          send_op(OP_APPEND, blk, $urandom);
        end else if (pick < 65) begin
          steps = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, len + 1);
          send_op(OP_WALK, blk, steps);
        end else if (pick < 77 || pick < 45) begin
          send_op(OP_FREE_CHAIN, blk, $urandom);
          chain_heads.delete(idx);
        end else if (pick < 85) begin
          send_op(OP_FREE_ONE, blk + $urandom_range(0, 3), $urandom);
        end else begin
          send_op(3'($urandom_range(OP_APPEND, OP_WALK)), $urandom, $urandom);
        end
      end else begin
        send_op(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), $urandom, $urandom);
      end
    end
  endtask

  task automatic test_alloc_burst();
    int blk;
    steady_flow = 1'b0;
    repeat (BURST_ITEMS) begin
      if (chain_heads.size() > 0 && $urandom_range(0, 2) == 0) begin
        blk = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
        if (chain_length(blk) < MAX_CHAIN) begin
          send_op(OP_APPEND, blk, $urandom);
        end else begin
          send_op(OP_WALK, blk, $urandom);
        end
      end else if (chain_heads.size() < MAX_HEADS) begin
        send_op(OP_ALLOC, $urandom, $urandom);
        if (last_outcome.status == ST_OK) begin
          chain_heads.push_back(int'(last_outcome.result_block));
        end
      end else begin
        send_op(OP_FREE_CHAIN, chain_heads[0], $urandom);
        chain_heads.delete(0);
      end
    end
    repeat (8) send_op(OP_FREE_CHAIN, $urandom_range(FIRST, BLOCKS - 1), $urandom);
    repeat (4) send_op(OP_ALLOC, $urandom, $urandom);
  endtask

  initial begin
    for (int b = 0; b < BLOCKS; b++) begin
      blk_used[b] = (b < FIRST);
      blk_next[b] = 13'(END_LINK);
    end
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_cases();
    test_random_mix();
    test_alloc_burst();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items: alloc %0d, append %0d, free chain %0d, free one %0d, walk %0d,",
             real_items + op_count[5] + op_count[6] + op_count[7], op_count[OP_ALLOC],
             op_count[OP_APPEND], op_count[OP_FREE_CHAIN], op_count[OP_FREE_ONE],
             op_count[OP_WALK]);
    $display("unused %0d; %0d results checked: ok %0d, disk full %0d, chain ended %0d.",
             op_count[5] + op_count[6] + op_count[7], checked_count, status_count[ST_OK],
             status_count[ST_NO_FREE], status_count[ST_ENDED]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
